FILE: rtl/core/htw_pkg.sv
package htw_pkg;

   localparam int NUM_TIMERS   = 64;
   localparam int LEVEL1_SLOTS = 256;
   localparam int OUTER_SLOTS  = 64;
   localparam int TICK_WIDTH   = 32;
   localparam int LEVEL1_BITS  = $clog2(LEVEL1_SLOTS);
   localparam int OUTER_BITS   = $clog2(OUTER_SLOTS);
   localparam int NUM_LEVELS   = 5;
   localparam int NUM_BUCKETS  = LEVEL1_SLOTS + (NUM_LEVELS - 1) * OUTER_SLOTS;
   localparam int BUCKET_W     = $clog2(NUM_BUCKETS);
   localparam int LEVEL_W      = 3;
   localparam int INFO_W       = 49;
   localparam int ID_W         = 6;

   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_CONFIG = 2'd1;
   localparam logic [1:0] ACT_START  = 2'd2;
   localparam logic [1:0] ACT_STOP   = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  timer_index;
      logic [31:0] delay_ticks;
      logic        use_callback;
      logic [15:0] task_id;
      logic [31:0] event_value;
   } req_type;

   typedef struct packed {
      logic        fired;
      logic [5:0]  expired_id;
      logic        by_callback;
      logic [15:0] target_task;
      logic [31:0] notify_value;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic              fire;
      logic              done;
      logic [ID_W-1:0]   id;
      logic [INFO_W-1:0] info;
   } evt_type;

   // Bucket in which a timer expiring at expiry is filed, seen from tick now.
   function automatic logic [BUCKET_W-1:0] file_bucket(input logic [TICK_WIDTH-1:0] expiry,
                                                       input logic [TICK_WIDTH-1:0] now);
      logic [TICK_WIDTH-1:0] offset;
      logic [TICK_WIDTH-1:0] shifted;
      logic [BUCKET_W-1:0]   bkt;
      int                    k;
      offset = expiry - now;
      bkt = BUCKET_W'(expiry[LEVEL1_BITS-1:0]);
      if ((offset >> LEVEL1_BITS) != '0) begin
         for (k = NUM_LEVELS - 1; k >= 1; k--) begin
            if (k == NUM_LEVELS - 1 || (offset >> (LEVEL1_BITS + k * OUTER_BITS)) == '0) begin
               shifted = expiry >> (LEVEL1_BITS + (k - 1) * OUTER_BITS);
               bkt = BUCKET_W'(LEVEL1_SLOTS + (k - 1) * OUTER_SLOTS)
                     + BUCKET_W'(shifted[OUTER_BITS-1:0]);
            end
         end
      end
      return bkt;
   endfunction

   // Current bucket of level lv at tick now.
   function automatic logic [BUCKET_W-1:0] drain_bucket(input logic [TICK_WIDTH-1:0] now,
                                                        input logic [LEVEL_W-1:0] lv);
      logic [TICK_WIDTH-1:0] shifted;
      logic [BUCKET_W-1:0]   bkt;
      int                    k;
      bkt = BUCKET_W'(now[LEVEL1_BITS-1:0]);
      for (k = 1; k < NUM_LEVELS; k++) begin
         if (lv == LEVEL_W'(k)) begin
            shifted = now >> (LEVEL1_BITS + (k - 1) * OUTER_BITS);
            bkt = BUCKET_W'(LEVEL1_SLOTS + (k - 1) * OUTER_SLOTS)
                  + BUCKET_W'(shifted[OUTER_BITS-1:0]);
         end
      end
      return bkt;
   endfunction

   // True when the slot index of level lv is zero, so the next level is walked too.
   function automatic logic level_wraps(input logic [TICK_WIDTH-1:0] now,
                                        input logic [LEVEL_W-1:0] lv);
      logic [TICK_WIDTH-1:0] shifted;
      logic                  wraps;
      int                    k;
      wraps = (now[LEVEL1_BITS-1:0] == '0);
      for (k = 1; k < NUM_LEVELS; k++) begin
         if (lv == LEVEL_W'(k)) begin
            shifted = now >> (LEVEL1_BITS + (k - 1) * OUTER_BITS);
            wraps = (shifted[OUTER_BITS-1:0] == '0);
         end
      end
      return wraps;
   endfunction

endpackage

FILE: rtl/core/htw_ram.sv
module htw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/htw_ctrl.sv
module htw_ctrl #(
   parameter int NUM_TIMERS = htw_pkg::NUM_TIMERS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  htw_pkg::req_type req,
   output logic             busy,
   output htw_pkg::evt_type evt
);

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int LW = $clog2(NUM_TIMERS + 1);
   localparam int BW = htw_pkg::BUCKET_W;
   localparam int TW = htw_pkg::TICK_WIDTH;
   localparam logic [LW-1:0] NIL = LW'(NUM_TIMERS);

   localparam logic [3:0] ST_CLEAR      = 4'd0;
   localparam logic [3:0] ST_IDLE       = 4'd1;
   localparam logic [3:0] ST_U_BKT      = 4'd2;
   localparam logic [3:0] ST_U_HEAD     = 4'd3;
   localparam logic [3:0] ST_U_FIRST    = 4'd4;
   localparam logic [3:0] ST_U_SCAN     = 4'd5;
   localparam logic [3:0] ST_U_FIX_HEAD = 4'd6;
   localparam logic [3:0] ST_U_FIX_LINK = 4'd7;
   localparam logic [3:0] ST_F_READ     = 4'd8;
   localparam logic [3:0] ST_F_WRITE    = 4'd9;
   localparam logic [3:0] ST_D_HEAD     = 4'd10;
   localparam logic [3:0] ST_D_LIST     = 4'd11;
   localparam logic [3:0] ST_D_NODE     = 4'd12;
   localparam logic [3:0] ST_D_EVAL     = 4'd13;

   logic [3:0]            state_ff, state_in;
   logic [BW-1:0]         clr_ff, clr_in;
   logic [TW-1:0]         tick_ff, tick_in;
   logic [NUM_TIMERS-1:0] run_ff, run_in;
   logic [IW-1:0]         id_ff, id_in;
   logic [TW-1:0]         exp_ff, exp_in;
   logic [BW-1:0]         b_ff, b_in;
   logic [BW-1:0]         fb_ff, fb_in;
   logic [LW-1:0]         prev_ff, prev_in;
   logic [LW-1:0]         cur_ff, cur_in;
   logic [htw_pkg::LEVEL_W-1:0] lv_ff, lv_in;
   logic                  stop_ff, stop_in;
   logic                  drain_ff, drain_in;

   logic                  head_we, link_we, bkt_we, exp_we, info_we;
   logic [BW-1:0]         head_wa, head_ra;
   logic [LW-1:0]         head_wd, head_rd;
   logic [IW-1:0]         link_wa, link_ra, bkt_wa, exp_wa, info_wa;
   logic [LW-1:0]         link_wd, link_rd;
   logic [BW-1:0]         bkt_wd, bkt_rd;
   logic [TW-1:0]         exp_wd, exp_rd;
   logic [htw_pkg::INFO_W-1:0] info_wd, info_rd;
   logic [LW-1:0]         id_ext;
   logic                  req_in_range;

   assign id_ext       = LW'(id_ff);
   assign req_in_range = (32'(req.timer_index) < NUM_TIMERS);
   assign busy         = (state_ff != ST_IDLE);

   htw_ram #(.WIDTH(LW), .DEPTH(htw_pkg::NUM_BUCKETS)) u_head (
      .clock(clock), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
      .rd_addr(head_ra), .rd_data(head_rd));
   htw_ram #(.WIDTH(LW), .DEPTH(NUM_TIMERS)) u_link (
      .clock(clock), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
      .rd_addr(link_ra), .rd_data(link_rd));
   htw_ram #(.WIDTH(BW), .DEPTH(NUM_TIMERS)) u_bucket (
      .clock(clock), .wr_en(bkt_we), .wr_addr(bkt_wa), .wr_data(bkt_wd),
      .rd_addr(id_ff), .rd_data(bkt_rd));
   htw_ram #(.WIDTH(TW), .DEPTH(NUM_TIMERS)) u_expiry (
      .clock(clock), .wr_en(exp_we), .wr_addr(exp_wa), .wr_data(exp_wd),
      .rd_addr(cur_ff[IW-1:0]), .rd_data(exp_rd));
   htw_ram #(.WIDTH(htw_pkg::INFO_W), .DEPTH(NUM_TIMERS)) u_info (
      .clock(clock), .wr_en(info_we), .wr_addr(info_wa), .wr_data(info_wd),
      .rd_addr(cur_ff[IW-1:0]), .rd_data(info_rd));

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      tick_in  = tick_ff;
      run_in   = run_ff;
      id_in    = id_ff;
      exp_in   = exp_ff;
      b_in     = b_ff;
      fb_in    = fb_ff;
      prev_in  = prev_ff;
      cur_in   = cur_ff;
      lv_in    = lv_ff;
      stop_in  = stop_ff;
      drain_in = drain_ff;

      head_we = 1'b0;
      head_wa = b_ff;
      head_wd = NIL;
      head_ra = b_ff;
      link_we = 1'b0;
      link_wa = id_ff;
      link_wd = head_rd;
      link_ra = id_ff;
      bkt_we  = 1'b0;
      bkt_wa  = id_ff;
      bkt_wd  = fb_ff;
      exp_we  = 1'b0;
      exp_wa  = req.timer_index[IW-1:0];
      exp_wd  = tick_ff + TW'(req.delay_ticks);
      info_we = 1'b0;
      info_wa = req.timer_index[IW-1:0];
      info_wd = {req.use_callback, req.task_id, req.event_value};

      evt.fire = 1'b0;
      evt.done = 1'b0;
      evt.id   = htw_pkg::ID_W'(cur_ff[IW-1:0]);
      evt.info = info_rd;

      case (state_ff)
         ST_CLEAR: begin
            head_we = 1'b1;
            head_wa = clr_ff;
            clr_in  = clr_ff + BW'(1);
            if (clr_ff == BW'(htw_pkg::NUM_BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start && req.action == htw_pkg::ACT_TICK) begin
               lv_in    = '0;
               state_in = ST_D_HEAD;
            end else if (start && req_in_range) begin
               id_in = req.timer_index[IW-1:0];
               case (req.action)
                  htw_pkg::ACT_CONFIG: begin
                     info_we = 1'b1;
                  end
                  htw_pkg::ACT_START: begin
                     exp_we   = 1'b1;
                     exp_in   = exp_wd;
                     stop_in  = 1'b0;
                     drain_in = 1'b0;
                     state_in = run_ff[req.timer_index[IW-1:0]] ? ST_U_BKT : ST_F_READ;
                  end
                  default: begin
                     stop_in = 1'b1;
                     if (run_ff[req.timer_index[IW-1:0]]) begin
                        state_in = ST_U_BKT;
                     end
                  end
               endcase
            end
         end
         ST_U_BKT: begin
            state_in = ST_U_HEAD;
         end
         ST_U_HEAD: begin
            b_in     = bkt_rd;
            head_ra  = bkt_rd;
            state_in = ST_U_FIRST;
         end
         ST_U_FIRST: begin
            if (head_rd == id_ext) begin
               state_in = ST_U_FIX_HEAD;
            end else begin
               prev_in  = head_rd;
               link_ra  = head_rd[IW-1:0];
               state_in = ST_U_SCAN;
            end
         end
         ST_U_SCAN: begin
            if (link_rd == id_ext) begin
               state_in = ST_U_FIX_LINK;
            end else begin
               prev_in  = link_rd;
               link_ra  = link_rd[IW-1:0];
            end
         end
         ST_U_FIX_HEAD, ST_U_FIX_LINK: begin
            // link_rd holds the successor of the timer being taken out.
            if (state_ff == ST_U_FIX_HEAD) begin
               head_we = 1'b1;
               head_wd = link_rd;
            end else begin
               link_we = 1'b1;
               link_wa = prev_ff[IW-1:0];
               link_wd = link_rd;
            end
            if (stop_ff) begin
               run_in[id_ff] = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_F_READ;
            end
         end
         ST_F_READ: begin
            fb_in    = htw_pkg::file_bucket(exp_ff, tick_ff);
            head_ra  = fb_in;
            state_in = ST_F_WRITE;
         end
         ST_F_WRITE: begin
            link_we = 1'b1;
            head_we = 1'b1;
            head_wa = fb_ff;
            head_wd = id_ext;
            bkt_we  = 1'b1;
            if (drain_ff) begin
               state_in = ST_D_NODE;
            end else begin
               run_in[id_ff] = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_D_HEAD: begin
            b_in     = htw_pkg::drain_bucket(tick_ff, lv_ff);
            head_ra  = b_in;
            state_in = ST_D_LIST;
         end
         ST_D_LIST: begin
            cur_in   = head_rd;
            head_we  = 1'b1;
            state_in = ST_D_NODE;
         end
         ST_D_NODE: begin
            if (cur_ff == NIL) begin
               if (lv_ff < htw_pkg::LEVEL_W'(htw_pkg::NUM_LEVELS - 1)
                   && htw_pkg::level_wraps(tick_ff, lv_ff)) begin
                  lv_in    = lv_ff + htw_pkg::LEVEL_W'(1);
                  state_in = ST_D_HEAD;
               end else begin
                  tick_in  = tick_ff + TW'(1);
                  evt.done = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               id_in    = cur_ff[IW-1:0];
               link_ra  = cur_ff[IW-1:0];
               state_in = ST_D_EVAL;
            end
         end
         ST_D_EVAL: begin
            cur_in   = link_rd;
            exp_in   = exp_rd;
            evt.id   = htw_pkg::ID_W'(id_ff);
            if (exp_rd == tick_ff) begin
               evt.fire      = 1'b1;
               run_in[id_ff] = 1'b0;
               state_in      = ST_D_NODE;
            end else begin
               drain_in = 1'b1;
               state_in = ST_F_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         tick_ff  <= '0;
         run_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         tick_ff  <= tick_in;
         run_ff   <= run_in;
      end
      id_ff    <= id_in;
      exp_ff   <= exp_in;
      b_ff     <= b_in;
      fb_ff    <= fb_in;
      prev_ff  <= prev_in;
      cur_ff   <= cur_in;
      lv_ff    <= lv_in;
      stop_ff  <= stop_in;
      drain_ff <= drain_in;
   end

endmodule

FILE: rtl/core/hierarchical_timer_wheel.sv
// Configure, and stop of an idle timer, are done without leaving idle; stop of a running timer reads its bucket
// and walks that bucket's list to unlink it. Start files the timer, unlinking it first when it was running.
// A tick drains the current bucket of each level walked, fires each timer due and re-files the others.
// Each result is held until the next one of its tick is found, so that the final one can carry
// last; that one appears in the cycle in which busy falls, and the receiver cannot stall.
// Synchronous reset clears the time and all timers, then empties the 512 buckets with busy high.
module hierarchical_timer_wheel #(
   parameter int NUM_TIMERS = htw_pkg::NUM_TIMERS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  htw_pkg::req_type req_item,
   output logic             rsp_strobe,
   output htw_pkg::rsp_type rsp_item
);

   htw_pkg::evt_type evt;
   htw_pkg::rsp_type rsp_ff, rsp_in;
   htw_pkg::rsp_type pend_ff, pend_in;
   htw_pkg::rsp_type fresh;
   logic             strobe_ff, strobe_in;
   logic             pend_valid_ff, pend_valid_in;

   htw_ctrl #(.NUM_TIMERS(NUM_TIMERS)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req(req_item),
      .busy(busy), .evt(evt));

   always_comb begin
      fresh.fired        = 1'b1;
      fresh.expired_id   = evt.id;
      fresh.by_callback  = evt.info[48];
      fresh.target_task  = evt.info[48] ? 16'd0 : evt.info[47:32];
      fresh.notify_value = evt.info[31:0];
      fresh.last         = 1'b0;

      // One result is held back so that the final one of a tick can carry last.
      strobe_in     = 1'b0;
      rsp_in        = rsp_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (evt.fire) begin
         strobe_in     = pend_valid_ff;
         rsp_in        = pend_ff;
         pend_in       = fresh;
         pend_valid_in = 1'b1;
      end else if (evt.done) begin
         strobe_in     = 1'b1;
         rsp_in        = pend_valid_ff ? pend_ff : '0;
         rsp_in.last   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         strobe_ff     <= strobe_in;
         pend_valid_ff <= pend_valid_in;
      end
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
